@@ rtl/core/tsps_pkg.sv @@
// package: types and constants of the tail swing pwm sequencer
`default_nettype none

package tsps_pkg;

    localparam int unsigned TIME_W     = 16;
    localparam int unsigned DUTY_W     = 8;
    localparam int unsigned CMP_W      = 16;
    localparam int unsigned SPEED_W    = 7;
    localparam int unsigned PROD_W     = SPEED_W + CMP_W;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [SPEED_W-1:0] FULL_DUTY      = 7'd100;
    localparam logic [TIME_W-1:0]  TURN_LONG_ADD  = 16'd400;
    localparam logic [TIME_W-1:0]  TURN_SHORT_ADD = 16'd300;
    localparam logic [CMP_W-1:0]   PWM_PERIOD_RST = 16'd999;

    localparam int unsigned RECIP_SHIFT = 30;
    localparam int unsigned RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] DUTY_RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd100 + 64'd1);
    localparam int unsigned SCALED_W    = RECIP_W + PROD_W;

    typedef enum logic [1:0] {
        MODE_HALT   = 2'd0,
        MODE_FWD    = 2'd1,
        MODE_TURN_L = 2'd2,
        MODE_TURN_R = 2'd3
    } mode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PWM_PERIOD   = 3'd0,
        REG_MODE_SETTING = 3'd1,
        REG_DUTY_SETTING = 3'd2,
        REG_OFFSET_LEFT  = 3'd3,
        REG_OFFSET_RIGHT = 3'd4,
        REG_LEFT_TIME    = 3'd5,
        REG_RIGHT_TIME   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [CMP_W-1:0]  pwm_period;
        mode_t             mode;
        logic [DUTY_W-1:0] duty;
        logic [DUTY_W-1:0] offset_left;
        logic [DUTY_W-1:0] offset_right;
        logic [TIME_W-1:0] left_time;
        logic [TIME_W-1:0] right_time;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic phase;
        logic chan_b;
    } stage_flags_t;

endpackage

`default_nettype wire

@@ rtl/core/tsps_if.sv @@
// interfaces: tick input, result output and register write channels
`default_nettype none

interface tsps_tick_if;
    import tsps_pkg::*;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] elapsed_ms;
    modport source (output valid, output elapsed_ms, input ready);
    modport sink (input valid, input elapsed_ms, output ready);
endinterface

interface tsps_result_if;
    import tsps_pkg::*;
    logic             valid;
    logic             ready;
    logic [CMP_W-1:0] compare_a;
    logic [CMP_W-1:0] compare_b;
    logic             busy_res;
    logic             swing_phase;
    modport source (output valid, output compare_a, output compare_b, output busy_res,
                    output swing_phase, input ready);
    modport sink (input valid, input compare_a, input compare_b, input busy_res,
                  input swing_phase, output ready);
endinterface

interface tsps_cfg_if;
    import tsps_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tsps_regs.sv @@
// configuration register file
`default_nettype none

module tsps_regs (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tsps_cfg_if.sink     cfg,
    output tsps_pkg::cfg_t regs
);
    import tsps_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (reg_idx_t'(cfg.addr))
                REG_PWM_PERIOD:   regs_next.pwm_period   = cfg.data;
                REG_MODE_SETTING: regs_next.mode         = mode_t'(cfg.data[1:0]);
                REG_DUTY_SETTING: regs_next.duty         = cfg.data[DUTY_W-1:0];
                REG_OFFSET_LEFT:  regs_next.offset_left  = cfg.data[DUTY_W-1:0];
                REG_OFFSET_RIGHT: regs_next.offset_right = cfg.data[DUTY_W-1:0];
                REG_LEFT_TIME:    regs_next.left_time    = cfg.data[TIME_W-1:0];
                REG_RIGHT_TIME:   regs_next.right_time   = cfg.data[TIME_W-1:0];
                default:          regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.pwm_period   <= PWM_PERIOD_RST;
            regs_reg.mode         <= MODE_HALT;
            regs_reg.duty         <= '0;
            regs_reg.offset_left  <= '0;
            regs_reg.offset_right <= '0;
            regs_reg.left_time    <= '0;
            regs_reg.right_time   <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tsps_ctrl.sv @@
// swing cycle state, phase sequencing and duty product stage
`default_nettype none

module tsps_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    tsps_tick_if.sink                         tick,
    input  wire tsps_pkg::cfg_t               regs,
    output logic                              s1_valid,
    input  wire logic                         s1_ready,
    output logic [tsps_pkg::PROD_W-1:0]       s1_product,
    output tsps_pkg::stage_flags_t            s1_flags
);
    import tsps_pkg::*;

    logic [TIME_W-1:0] cycle_time_reg;
    logic              running_reg;
    logic              phase_reg;
    mode_t             lmode_reg;
    logic [DUTY_W-1:0] lduty_reg;
    logic [DUTY_W-1:0] loff_l_reg;
    logic [DUTY_W-1:0] loff_r_reg;
    logic [TIME_W-1:0] ltime_l_reg;
    logic [TIME_W-1:0] ltime_r_reg;

    logic              s1_valid_reg;
    logic [PROD_W-1:0] product_reg;
    stage_flags_t      flags_reg;

    mode_t             mode;
    logic [DUTY_W-1:0] duty;
    logic [DUTY_W-1:0] off_l;
    logic [DUTY_W-1:0] off_r;
    logic [TIME_W-1:0] time_l;
    logic [TIME_W-1:0] time_r;
    logic [TIME_W-1:0] cur_time;
    logic [TIME_W-1:0] t1;
    logic [TIME_W-1:0] t2;
    logic [TIME_W:0]   t_sum;
    logic              fwd_first;
    logic              drive_fwd;
    logic [DUTY_W-1:0] sel_off;
    logic [DUTY_W:0]   diff;
    logic [SPEED_W-1:0] speed;
    logic              running_next;
    logic              phase_next;
    logic [TIME_W-1:0] cycle_time_next;
    logic [PROD_W-1:0] product_next;
    logic              accept;

    assign tick.ready = !s1_valid_reg || s1_ready;
    assign accept     = tick.valid && tick.ready;
    assign s1_valid   = s1_valid_reg;
    assign s1_product = product_reg;
    assign s1_flags   = flags_reg;

    always_comb
    begin
        // a new cycle takes its settings from the registers
        if (!running_reg)
        begin
            mode     = regs.mode;
            duty     = regs.duty;
            off_l    = regs.offset_left;
            off_r    = regs.offset_right;
            time_l   = regs.left_time;
            time_r   = regs.right_time;
            cur_time = '0;
        end
        else
        begin
            mode     = lmode_reg;
            duty     = lduty_reg;
            off_l    = loff_l_reg;
            off_r    = loff_r_reg;
            time_l   = ltime_l_reg;
            time_r   = ltime_r_reg;
            cur_time = cycle_time_reg;
        end

        unique case (mode)
            MODE_TURN_L:
            begin
                t1        = time_l + TURN_LONG_ADD;
                t2        = time_r + TURN_SHORT_ADD;
                fwd_first = 1'b1;
            end
            MODE_TURN_R:
            begin
                t1        = time_r + TURN_LONG_ADD;
                t2        = time_l + TURN_SHORT_ADD;
                fwd_first = 1'b0;
            end
            default:
            begin
                t1        = time_l;
                t2        = time_r;
                fwd_first = 1'b1;
            end
        endcase

        t_sum     = {1'b0, t1} + {1'b0, t2};
        drive_fwd = (phase_reg == 1'b0) == fwd_first;
        sel_off   = drive_fwd ? off_l : off_r;
        diff      = {1'b0, duty} - {1'b0, sel_off};

        // clamp to 0..100
        if (diff[DUTY_W])
            speed = '0;
        else if (diff[DUTY_W-1:0] > DUTY_W'(FULL_DUTY))
            speed = FULL_DUTY;
        else
            speed = diff[SPEED_W-1:0];

        running_next = 1'b1;
        phase_next   = phase_reg;
        product_next = PROD_W'(speed) * PROD_W'(regs.pwm_period);

        if (mode == MODE_HALT)
        begin
            running_next = 1'b0;
            product_next = '0;
        end
        else if (phase_reg == 1'b0)
        begin
            if (cur_time == t1)
                phase_next = 1'b1;
        end
        else if ({1'b0, cur_time} == t_sum)
        begin
            phase_next   = 1'b0;
            running_next = 1'b0;
        end

        cycle_time_next = cur_time + tick.elapsed_ms;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_time_reg <= '0;
            running_reg    <= 1'b0;
            phase_reg      <= 1'b0;
            lmode_reg      <= MODE_HALT;
            lduty_reg      <= '0;
            loff_l_reg     <= '0;
            loff_r_reg     <= '0;
            ltime_l_reg    <= '0;
            ltime_r_reg    <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (tick.ready)
                s1_valid_reg <= tick.valid;
            if (accept)
            begin
                cycle_time_reg <= cycle_time_next;
                running_reg    <= running_next;
                phase_reg      <= phase_next;
                lmode_reg      <= mode;
                lduty_reg      <= duty;
                loff_l_reg     <= off_l;
                loff_r_reg     <= off_r;
                ltime_l_reg    <= time_l;
                ltime_r_reg    <= time_r;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            product_reg      <= product_next;
            flags_reg.busy   <= running_next;
            flags_reg.phase  <= phase_next;
            flags_reg.chan_b <= !drive_fwd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tsps_scale.sv @@
// divide by full duty through a reciprocal multiply, result register
`default_nettype none

module tsps_scale (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s1_valid,
    output logic                        s1_ready,
    input  wire logic [tsps_pkg::PROD_W-1:0] s1_product,
    input  wire tsps_pkg::stage_flags_t s1_flags,
    tsps_result_if.source               result
);
    import tsps_pkg::*;

    logic               out_valid_reg;
    logic [CMP_W-1:0]   cmp_a_reg;
    logic [CMP_W-1:0]   cmp_b_reg;
    logic               busy_reg;
    logic               phase_reg;

    logic [SCALED_W-1:0] scaled;
    logic [CMP_W-1:0]    quotient;
    logic                xfer;

    assign s1_ready = !out_valid_reg || result.ready;
    assign xfer     = s1_valid && s1_ready;

    // floor(product / 100), exact for every product below 100 * 2^16
    assign scaled   = SCALED_W'(s1_product) * SCALED_W'(DUTY_RECIP);
    assign quotient = scaled[RECIP_SHIFT +: CMP_W];

    assign result.valid       = out_valid_reg;
    assign result.compare_a   = cmp_a_reg;
    assign result.compare_b   = cmp_b_reg;
    assign result.busy_res    = busy_reg;
    assign result.swing_phase = phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_ready)
            out_valid_reg <= s1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            cmp_a_reg <= s1_flags.chan_b ? '0 : quotient;
            cmp_b_reg <= s1_flags.chan_b ? quotient : '0;
            busy_reg  <= s1_flags.busy;
            phase_reg <= s1_flags.phase;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tail_swing_pwm_sequencer_core.sv @@
// top level of the tail swing pwm sequencer
//
// Each tick transfer yields exactly one result transfer when the result side is ready;
// a new tick is taken every cycle unless stalled. The first stage updates the swing
// cycle state (latch at cycle start, phase ends by exact time match, time counter
// advance) and registers speed * pwm_period from one 7x16 multiplier; the second stage
// divides by 100 with a constant reciprocal multiplier into the result register.
// Settings are latched at the start of each swing cycle, pwm_period is used live.
// Register writes are always taken and should be issued only while the block is idle.
`default_nettype none

module tail_swing_pwm_sequencer_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tsps_cfg_if.sink      cfg,
    tsps_tick_if.sink     tick,
    tsps_result_if.source result
);
    import tsps_pkg::*;

    cfg_t              regs;
    logic              s1_valid;
    logic              s1_ready;
    logic [PROD_W-1:0] s1_product;
    stage_flags_t      s1_flags;

    tsps_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    tsps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .regs       (regs),
        .s1_valid   (s1_valid),
        .s1_ready   (s1_ready),
        .s1_product (s1_product),
        .s1_flags   (s1_flags)
    );

    tsps_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid),
        .s1_ready   (s1_ready),
        .s1_product (s1_product),
        .s1_flags   (s1_flags),
        .result     (result)
    );

endmodule

`default_nettype wire

@@ tb/tb_tail_swing_pwm_sequencer_core.sv @@
// testbench: drives ticks and register writes, checks every result against a built-in model
`timescale 1ns / 1ps

module tb_tail_swing_pwm_sequencer_core;

    import tsps_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED  = 3'd7;
    localparam int                    STALL_LIMIT = 1000;

    typedef struct packed {
        logic [TIME_W-1:0] clock_ms;
        logic              active;
        logic              second;
        mode_t             mode;
        logic [DUTY_W-1:0] duty;
        logic [DUTY_W-1:0] offl;
        logic [DUTY_W-1:0] offr;
        logic [TIME_W-1:0] ltime;
        logic [TIME_W-1:0] rtime;
    } swing_state_t;

    typedef struct packed {
        logic [CMP_W-1:0] compare_a;
        logic [CMP_W-1:0] compare_b;
        logic             busy;
        logic             phase;
    } swing_out_t;

    logic clk;
    logic rst_n;

    tsps_tick_if   tick_ch ();
    tsps_result_if res_ch ();
    tsps_cfg_if    cfg_ch ();

    tail_swing_pwm_sequencer_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .tick   (tick_ch),
        .result (res_ch)
    );

    cfg_t         shadow_regs;
    swing_state_t swing;
    swing_out_t   expected_results[$];
    int           mismatches;
    int           results_seen;
    int           quiet_cycles;
    int           hold_len;
    bit           calm;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [CMP_W-1:0] pwm_compare(input logic [DUTY_W-1:0] duty,
                                                     input logic [DUTY_W-1:0] offset,
                                                     input logic [CMP_W-1:0] period);
        int speed;
        speed = int'(duty) - int'(offset);
        if (speed < 0)
            speed = 0;
        if (speed > int'(FULL_DUTY))
            speed = int'(FULL_DUTY);
        return CMP_W'((speed * int'(period)) / int'(FULL_DUTY));
    endfunction

    function automatic void swing_limits(input mode_t m, input logic [TIME_W-1:0] lt,
                                         input logic [TIME_W-1:0] rt,
                                         output logic [TIME_W-1:0] t1,
                                         output logic [TIME_W-1:0] t2,
                                         output logic fwd_first);
        case (m)
            MODE_TURN_L:
            begin
                t1 = lt + TURN_LONG_ADD;
                t2 = rt + TURN_SHORT_ADD;
                fwd_first = 1'b1;
            end
            MODE_TURN_R:
            begin
                t1 = rt + TURN_LONG_ADD;
                t2 = lt + TURN_SHORT_ADD;
                fwd_first = 1'b0;
            end
            default:
            begin
                t1 = lt;
                t2 = rt;
                fwd_first = 1'b1;
            end
        endcase
    endfunction

    function automatic swing_out_t swing_step(inout swing_state_t s, input cfg_t c,
                                              input logic [TIME_W-1:0] elapsed);
        swing_out_t        r;
        logic [TIME_W-1:0] t1;
        logic [TIME_W-1:0] t2;
        logic              fwd_first;
        logic [TIME_W:0]   span;
        r = '0;
        if (!s.active)
        begin
            s.mode     = c.mode;
            s.duty     = c.duty;
            s.offl     = c.offset_left;
            s.offr     = c.offset_right;
            s.ltime    = c.left_time;
            s.rtime    = c.right_time;
            s.active   = 1'b1;
            s.clock_ms = '0;
        end
        if (s.mode == MODE_HALT)
            s.active = 1'b0;
        else
        begin
            swing_limits(s.mode, s.ltime, s.rtime, t1, t2, fwd_first);
            span = {1'b0, t1} + {1'b0, t2};
            if ((s.second == 1'b0) == fwd_first)
                r.compare_a = pwm_compare(s.duty, s.offl, c.pwm_period);
            else
                r.compare_b = pwm_compare(s.duty, s.offr, c.pwm_period);
            if (!s.second)
            begin
                if (s.clock_ms == t1)
                    s.second = 1'b1;
            end
            else if ({1'b0, s.clock_ms} == span)
            begin
                s.second = 1'b0;
                s.active = 1'b0;
            end
        end
        s.clock_ms = s.clock_ms + elapsed;
        r.busy  = s.active;
        r.phase = s.second;
        return r;
    endfunction

    // mostly steps that land exactly on the next phase end, some short, some wild
    function automatic logic [TIME_W-1:0] aim_elapsed();
        swing_state_t      s;
        logic [TIME_W-1:0] t1;
        logic [TIME_W-1:0] t2;
        logic              fwd_first;
        logic [TIME_W:0]   target;
        logic [TIME_W-1:0] remain_ms;
        int                pick;
        s = swing;
        void'(swing_step(s, shadow_regs, '0));
        pick = $urandom_range(0, 99);
        swing_limits(s.mode, s.ltime, s.rtime, t1, t2, fwd_first);
        target = s.second ? ({1'b0, t1} + {1'b0, t2}) : {1'b0, t1};
        if (!s.active || target[TIME_W] || pick >= 90)
            return TIME_W'($urandom);
        remain_ms = target[TIME_W-1:0] - s.clock_ms;
        if (pick < 55)
            return remain_ms;
        else if (pick < 80)
            return TIME_W'($urandom_range(0, int'(remain_ms)));
        else
            return TIME_W'($urandom_range(0, 1));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        mismatches++;
        $display("mismatch in result %0d: %s got %0d expected %0d",
                 results_seen, what, got, exp_val);
    endtask

    task automatic send_tick(input logic [TIME_W-1:0] elapsed);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        cfg_ch.valid <= 1'b0;
        if (gap != 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.elapsed_ms <= elapsed;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        expected_results.push_back(swing_step(swing, shadow_regs, elapsed));
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_PWM_PERIOD:   shadow_regs.pwm_period   = data;
            REG_MODE_SETTING: shadow_regs.mode         = mode_t'(data[1:0]);
            REG_DUTY_SETTING: shadow_regs.duty         = data[DUTY_W-1:0];
            REG_OFFSET_LEFT:  shadow_regs.offset_left  = data[DUTY_W-1:0];
            REG_OFFSET_RIGHT: shadow_regs.offset_right = data[DUTY_W-1:0];
            REG_LEFT_TIME:    shadow_regs.left_time    = data;
            REG_RIGHT_TIME:   shadow_regs.right_time   = data;
            default: ;
        endcase
    endtask

    task automatic settle();
        tick_ch.valid <= 1'b0;
        cfg_ch.valid  <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic test_idle_after_reset();
        send_tick(16'h0000);
        send_tick(16'hFFFF);
    endtask

    task automatic test_forward_swing();
        settle();
        write_reg(REG_PWM_PERIOD, 16'hFFFF);
        write_reg(REG_MODE_SETTING, 16'(MODE_FWD));
        write_reg(REG_DUTY_SETTING, 16'd100);
        write_reg(REG_OFFSET_LEFT, 16'd0);
        write_reg(REG_OFFSET_RIGHT, 16'd255);
        write_reg(REG_LEFT_TIME, 16'd2);
        write_reg(REG_RIGHT_TIME, 16'd1);
        repeat (4) send_tick(16'd1);
    endtask

    task automatic test_turn_left();
        settle();
        write_reg(REG_PWM_PERIOD, 16'd999);
        write_reg(REG_MODE_SETTING, 16'(MODE_TURN_L));
        write_reg(REG_DUTY_SETTING, 16'hFFFF);
        write_reg(REG_OFFSET_LEFT, 16'd200);
        write_reg(REG_OFFSET_RIGHT, 16'd0);
        write_reg(REG_LEFT_TIME, 16'd65136);
        write_reg(REG_RIGHT_TIME, 16'd0);
        send_tick(16'd300);
        send_tick(16'd0);
    endtask

    // reverse drive first, then a step that overshoots and wraps the counter
    task automatic test_turn_right();
        settle();
        write_reg(REG_PWM_PERIOD, 16'd4321);
        write_reg(REG_MODE_SETTING, 16'(MODE_TURN_R));
        write_reg(REG_DUTY_SETTING, 16'd50);
        write_reg(REG_OFFSET_LEFT, 16'd60);
        write_reg(REG_OFFSET_RIGHT, 16'd10);
        write_reg(REG_LEFT_TIME, 16'd0);
        write_reg(REG_RIGHT_TIME, 16'd0);
        send_tick(16'd400);
        send_tick(16'hFFFF);
        send_tick(16'd301);
        send_tick(16'd0);
    endtask

    task automatic test_write_during_cycle();
        settle();
        write_reg(REG_PWM_PERIOD, 16'd0);
        write_reg(REG_MODE_SETTING, 16'(MODE_FWD));
        write_reg(REG_DUTY_SETTING, 16'd70);
        write_reg(REG_OFFSET_LEFT, 16'd20);
        write_reg(REG_OFFSET_RIGHT, 16'd0);
        write_reg(REG_LEFT_TIME, 16'd5);
        write_reg(REG_RIGHT_TIME, 16'd5);
        send_tick(16'd2);
        send_tick(16'd3);
        settle();
        write_reg(REG_PWM_PERIOD, 16'd1234);
        write_reg(REG_MODE_SETTING, 16'(MODE_HALT));
        write_reg(REG_DUTY_SETTING, 16'd0);
        write_reg(REG_UNUSED, 16'($urandom));
        send_tick(16'd5);
        send_tick(16'd0);
        send_tick(16'd0);
    endtask

    task automatic test_backpressure();
        settle();
        write_reg(REG_MODE_SETTING, 16'(MODE_FWD));
        write_reg(REG_DUTY_SETTING, 16'd90);
        write_reg(REG_LEFT_TIME, 16'd7);
        write_reg(REG_RIGHT_TIME, 16'd9);
        calm     = 1'b1;
        hold_len = 60;
        repeat (40) send_tick(aim_elapsed());
        calm = 1'b0;
    endtask

    task automatic test_random_rounds();
        logic [CFG_DATA_W-1:0] word;
        int                    pick;
        for (int r = 0; r < 20; r++)
        begin
            settle();
            calm = (r % 5 == 4);
            pick = $urandom_range(0, 9);
            word = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom);
            if ($urandom_range(0, 9) < 6)
                write_reg(REG_PWM_PERIOD, word);
            word = 16'($urandom);
            word[1:0] = ($urandom_range(0, 7) == 0) ? MODE_HALT : 2'($urandom_range(1, 3));
            write_reg(REG_MODE_SETTING, word);
            word = 16'($urandom);
            if ($urandom_range(0, 9) < 6)
                write_reg(REG_DUTY_SETTING, word);
            word = 16'($urandom);
            if ($urandom_range(0, 2) != 0)
                word[7:0] = 8'($urandom_range(0, 40));
            if ($urandom_range(0, 9) < 6)
                write_reg(REG_OFFSET_LEFT, word);
            word = 16'($urandom);
            if ($urandom_range(0, 2) != 0)
                word[7:0] = 8'($urandom_range(0, 40));
            if ($urandom_range(0, 9) < 6)
                write_reg(REG_OFFSET_RIGHT, word);
            for (int k = 0; k < 2; k++)
            begin
                pick = $urandom_range(0, 9);
                word = (pick < 6) ? 16'($urandom_range(0, 60)) :
                       (pick < 9) ? 16'($urandom_range(0, 3000)) : 16'($urandom_range(0, 30000));
                if ($urandom_range(0, 9) < 7)
                    write_reg(k == 0 ? REG_LEFT_TIME : REG_RIGHT_TIME, word);
            end
            repeat (22) send_tick(aim_elapsed());
        end
    endtask

    // second phase can never end once both times are at their maximum
    task automatic test_counter_overrun();
        int tries;
        settle();
        write_reg(REG_MODE_SETTING, 16'(MODE_FWD));
        write_reg(REG_DUTY_SETTING, 16'd255);
        write_reg(REG_OFFSET_LEFT, 16'd0);
        write_reg(REG_OFFSET_RIGHT, 16'd0);
        write_reg(REG_LEFT_TIME, 16'hFFFF);
        write_reg(REG_RIGHT_TIME, 16'hFFFF);
        tries = 0;
        while (swing.active && tries < 200)
        begin
            send_tick(aim_elapsed());
            tries++;
        end
        repeat (20) send_tick(aim_elapsed());
        settle();
        write_reg(REG_PWM_PERIOD, 16'd7);
        repeat (6) send_tick(aim_elapsed());
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        tick_ch.valid      <= 1'b0;
        tick_ch.elapsed_ms <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.addr        <= '0;
        cfg_ch.data        <= '0;
        shadow_regs              = '0;
        shadow_regs.pwm_period   = PWM_PERIOD_RST;
        shadow_regs.mode         = MODE_HALT;
        swing                    = '0;
        swing.mode               = MODE_HALT;
        mismatches   = 0;
        results_seen = 0;
        hold_len     = 0;
        calm         = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_after_reset();
        test_forward_swing();
        test_turn_left();
        test_turn_right();
        test_write_during_cycle();
        test_backpressure();
        test_random_rounds();
        test_counter_overrun();
        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : result_sink
        int pause;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            pause = calm ? 0 : $urandom_range(0, 5);
            if (hold_len != 0)
            begin
                pause    = hold_len;
                hold_len = 0;
            end
            if (pause != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        swing_out_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("transfer with nothing pending, compare_a", res_ch.compare_a, 0);
            else
            begin
                want = expected_results.pop_front();
                if (res_ch.compare_a !== want.compare_a)
                    report_mismatch("compare_a", res_ch.compare_a, want.compare_a);
                if (res_ch.compare_b !== want.compare_b)
                    report_mismatch("compare_b", res_ch.compare_b, want.compare_b);
                if (res_ch.busy_res !== want.busy)
                    report_mismatch("busy_res", res_ch.busy_res, want.busy);
                if (res_ch.swing_phase !== want.phase)
                    report_mismatch("swing_phase", res_ch.swing_phase, want.phase);
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
